/* rtl/core/q32fx_pkg.sv */
// ----------------------------------------------------------------------------
// q32fx_pkg
// Shared types and constants of the Q32.32 fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package q32fx_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned DIV_NUM_W = DATA_W + FRAC_W;  // numerator bits walked
  localparam int unsigned DIV_BITS  = 2;                // quotient bits per stage
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd1;

  typedef enum logic [3:0] {
    OP_ABS         = 4'd0,
    OP_MUL_Q32     = 4'd1,
    OP_DIV_Q32     = 4'd2,
    OP_QUANTIZE    = 4'd3,
    OP_CLAMP_UNIT  = 4'd4,
    OP_CLAMP_BAND  = 4'd5,
    OP_PHASE_DELTA = 4'd6,
    OP_MUL_Q63     = 4'd7,
    OP_MUL_LOW     = 4'd8,
    OP_FROM_INT    = 4'd9
  } op_e;

  // Restoring divider state between stages.
  typedef struct packed {
    logic [DATA_W-1:0]    rem;
    logic [DATA_W-1:0]    quo;
    logic [DIV_NUM_W-1:0] num;
    logic [DATA_W-1:0]    den;
  } div_t;

  // Per-item side data that travels next to the divider.
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              q_neg;
    logic              b_zero;
    logic [DATA_W-1:0] res;
  } side_t;

endpackage

/* rtl/core/q32fx_div_stage.sv */
// ----------------------------------------------------------------------------
// q32fx_div_stage
// One registered stage of the unsigned restoring divider: StepBits quotient
// bits per stage.
// ----------------------------------------------------------------------------
module q32fx_div_stage #(
  parameter int unsigned StepBits = q32fx_pkg::DIV_BITS
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  q32fx_pkg::div_t   div_i,
  output q32fx_pkg::div_t   div_o
);

  localparam int unsigned DW = q32fx_pkg::DATA_W;
  localparam int unsigned NW = q32fx_pkg::DIV_NUM_W;

  q32fx_pkg::div_t div_d, div_q;

  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [DW-1:0] q;
    logic [NW-1:0] n;
    r = div_i.rem;
    q = div_i.quo;
    n = div_i.num;
    t = '0;
    for (int i = 0; i < int'(StepBits); i++) begin
      t = {r, n[NW-1]};
      n = {n[NW-2:0], 1'b0};
      if (t >= {1'b0, div_i.den}) begin
        t = t - {1'b0, div_i.den};
        q = {q[DW-2:0], 1'b1};
      end else begin
        q = {q[DW-2:0], 1'b0};
      end
      r = t[DW-1:0];
    end
    div_d.rem = r;
    div_d.quo = q;
    div_d.num = n;
    div_d.den = div_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* rtl/core/q32_32_fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// q32_32_fixed_point_alu
// Q32.32 fixed-point arithmetic unit with pipelined multiply and divide.
// ----------------------------------------------------------------------------
// Every item takes the same fixed path: input register, operand stage, then
// DIV_NUM_W/DivBits divider stages (48 at the default of two quotient bits per
// stage), then the output register, for every operation. One item enters per
// cycle; the whole pipe holds only while the output register is full and not
// taken. The user must write band registers through the configuration port only
// while no item is in flight; the block itself does not enforce this.
module q32_32_fixed_point_alu #(
  parameter int unsigned DivBits = q32fx_pkg::DIV_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [3:0]                         operation_i,
  input  logic [q32fx_pkg::DATA_W-1:0]       operand_a_i,
  input  logic [q32fx_pkg::DATA_W-1:0]       operand_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [q32fx_pkg::DATA_W-1:0]       result_o,
  output logic                               divide_by_zero_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [q32fx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [q32fx_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DW     = q32fx_pkg::DATA_W;
  localparam int unsigned FW     = q32fx_pkg::FRAC_W;
  localparam int unsigned HW     = DW / 2;
  localparam int unsigned NW     = q32fx_pkg::DIV_NUM_W;
  localparam int unsigned KStage = NW / DivBits;

  logic en;

  // Configuration
  logic [DW-1:0] band_low_q, band_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= '0;
      band_high_q <= q32fx_pkg::ONE_Q32;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == q32fx_pkg::REG_BAND_LOW) begin
        band_low_q <= cfg_data_i;
      end else if (cfg_index_i == q32fx_pkg::REG_BAND_HIGH) begin
        band_high_q <= cfg_data_i;
      end
    end
  end

  // Valid bits
  logic              v_s1_q, v_s2_q, v_out_q;
  logic [KStage-1:0] v_div_q;

  assign en         = !v_out_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q  <= 1'b0;
      v_s2_q  <= 1'b0;
      v_div_q <= '0;
      v_out_q <= 1'b0;
    end else if (en) begin
      v_s1_q  <= in_valid_i;
      v_s2_q  <= v_s1_q;
      v_div_q <= {v_div_q[KStage-2:0], v_s2_q};
      v_out_q <= v_div_q[KStage-1];
    end
  end

  // Stage 1: input register
  q32fx_pkg::op_e s1_op_q;
  logic [DW-1:0]  s1_a_q, s1_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= q32fx_pkg::op_e'(operation_i);
      s1_a_q  <= operand_a_i;
      s1_b_q  <= operand_b_i;
    end
  end

  // Stage 2: magnitudes, partial products, simple results
  logic [DW-1:0]    ma, mb, simple_res;
  q32fx_pkg::side_t s2_side_d, s2_side_q;
  q32fx_pkg::div_t  s2_div_d, s2_div_q;
  logic [DW-1:0]    pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;

  assign ma = s1_a_q[DW-1] ? (DW'(0) - s1_a_q) : s1_a_q;
  assign mb = s1_b_q[DW-1] ? (DW'(0) - s1_b_q) : s1_b_q;

  always_comb begin
    unique case (s1_op_q)
      q32fx_pkg::OP_ABS: simple_res = ma;
      q32fx_pkg::OP_CLAMP_UNIT: begin
        if (s1_a_q[DW-1]) begin
          simple_res = '0;
        end else if (s1_a_q > q32fx_pkg::ONE_Q32) begin
          simple_res = q32fx_pkg::ONE_Q32;
        end else begin
          simple_res = s1_a_q;
        end
      end
      q32fx_pkg::OP_CLAMP_BAND: begin
        if ($signed(s1_a_q) < $signed(band_low_q)) begin
          simple_res = band_low_q;
        end else if ($signed(band_high_q) < $signed(s1_a_q)) begin
          simple_res = band_high_q;
        end else begin
          simple_res = s1_a_q;
        end
      end
      q32fx_pkg::OP_PHASE_DELTA: simple_res = s1_b_q - s1_a_q;
      q32fx_pkg::OP_FROM_INT:    simple_res = {s1_a_q[DW-FW-1:0], {FW{1'b0}}};
      default:                   simple_res = '0;
    endcase
  end

  always_comb begin
    s2_side_d.op     = s1_op_q;
    s2_side_d.a      = s1_a_q;
    s2_side_d.b      = s1_b_q;
    s2_side_d.q_neg  = s1_a_q[DW-1] ^ s1_b_q[DW-1];
    s2_side_d.b_zero = (s1_b_q == '0);
    s2_side_d.res    = simple_res;
    s2_div_d.rem     = '0;
    s2_div_d.quo     = '0;
    s2_div_d.den     = mb;
    // Divide walks ma scaled by 2^32; quantize walks ma alone.
    if (s1_op_q == q32fx_pkg::OP_DIV_Q32) begin
      s2_div_d.num = {ma, {FW{1'b0}}};
    end else begin
      s2_div_d.num = {{FW{1'b0}}, ma};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s2_side_d;
      s2_div_q  <= s2_div_d;
      pp_ll_q   <= s1_a_q[HW-1:0]  * s1_b_q[HW-1:0];
      pp_lh_q   <= s1_a_q[HW-1:0]  * s1_b_q[DW-1:HW];
      pp_hl_q   <= s1_a_q[DW-1:HW] * s1_b_q[HW-1:0];
      pp_hh_q   <= s1_a_q[DW-1:HW] * s1_b_q[DW-1:HW];
    end
  end

  // Divider chain with side data alongside
  q32fx_pkg::div_t  div_q  [KStage];
  q32fx_pkg::side_t side_q [KStage];
  logic [2*DW-1:0]  prod_q;
  logic [DW-1:0]    prod_hi;
  q32fx_pkg::side_t side1_d;

  for (genvar j = 0; j < KStage; j++) begin : g_div
    if (j == 0) begin : g_first
      q32fx_div_stage #(.StepBits(DivBits)) u_stage (
        .clk_i (clk_i),
        .en_i  (en),
        .div_i (s2_div_q),
        .div_o (div_q[j])
      );
    end else begin : g_rest
      q32fx_div_stage #(.StepBits(DivBits)) u_stage (
        .clk_i (clk_i),
        .en_i  (en),
        .div_i (div_q[j-1]),
        .div_o (div_q[j])
      );
    end
  end

  // Unsigned product sum, then sign correction of the high half
  assign prod_hi = prod_q[2*DW-1:DW]
                   - (side_q[0].a[DW-1] ? side_q[0].b : DW'(0))
                   - (side_q[0].b[DW-1] ? side_q[0].a : DW'(0));

  always_comb begin
    side1_d = side_q[0];
    unique case (side_q[0].op)
      q32fx_pkg::OP_MUL_Q32: side1_d.res = {prod_hi[FW-1:0], prod_q[DW-1:FW]};
      q32fx_pkg::OP_MUL_Q63: side1_d.res = {prod_hi[DW-2:0], prod_q[DW-1]};
      q32fx_pkg::OP_MUL_LOW: side1_d.res = prod_q[DW-1:0];
      default:               side1_d.res = side_q[0].res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s2_side_q;
      prod_q    <= {pp_hh_q, {DW{1'b0}}}
                   + {{HW{1'b0}}, pp_lh_q, {HW{1'b0}}}
                   + {{HW{1'b0}}, pp_hl_q, {HW{1'b0}}}
                   + {{DW{1'b0}}, pp_ll_q};
      side_q[1] <= side1_d;
      for (int j = 2; j < int'(KStage); j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Output register
  q32fx_pkg::side_t last_side;
  q32fx_pkg::div_t  last_div;
  logic [DW-1:0]    final_res, rem_signed;
  logic             final_dz;
  q32fx_pkg::op_e   out_op_q;
  logic [DW-1:0]    result_q;
  logic             dz_q;

  assign last_side  = side_q[KStage-1];
  assign last_div   = div_q[KStage-1];
  assign rem_signed = last_side.a[DW-1] ? (DW'(0) - last_div.rem) : last_div.rem;

  always_comb begin
    final_dz = 1'b0;
    unique case (last_side.op)
      q32fx_pkg::OP_DIV_Q32: begin
        if (last_side.b_zero) begin
          final_res = '0;
          final_dz  = 1'b1;
        end else begin
          final_res = last_side.q_neg ? (DW'(0) - last_div.quo) : last_div.quo;
        end
      end
      q32fx_pkg::OP_QUANTIZE: begin
        final_res = last_side.b_zero ? last_side.a : (last_side.a - rem_signed);
      end
      default: final_res = last_side.res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= final_res;
      dz_q     <= final_dz;
      out_op_q <= last_side.op;
    end
  end

  assign out_valid_o      = v_out_q;
  assign result_o         = result_q;
  assign divide_by_zero_o = dz_q;

  // Checks
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_out_q && dz_q |-> result_q == '0)
    else $error("divide-by-zero item with nonzero result");

  a_dz_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_out_q && dz_q |-> out_op_q == q32fx_pkg::OP_DIV_Q32)
    else $error("divide-by-zero flag on a non-divide item");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_out_q |-> in_ready_o)
    else $error("input held while output register is empty");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q32.32 arithmetic unit: directed corner items,
// then random traffic with random gaps and output stalls, through several
// band register settings. Every result is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_item_t;

  typedef struct packed {
    logic [63:0] res;
    logic        dbz;
  } alu_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  operation_i = '0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_o;
  logic        divide_by_zero_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [q32fx_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  alu_item_t   pending_items[$];
  alu_res_t    expected_results[$];
  logic [63:0] band_lo_m = 64'd0;
  logic [63:0] band_hi_m = q32fx_pkg::ONE_Q32;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          gaps_on = 1'b1;

  q32_32_fixed_point_alu u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic alu_res_t predict_alu(alu_item_t it);
    alu_res_t          r;
    logic signed [127:0] prod;
    logic [127:0]      num;
    logic [127:0]      quo;
    logic [63:0]       ma, mb, rm;
    r = '0;
    prod = $signed(it.a) * $signed(it.b);
    ma = abs64(it.a);
    mb = abs64(it.b);
    case (it.op)
      q32fx_pkg::OP_ABS:        r.res = ma;
      q32fx_pkg::OP_MUL_Q32:    r.res = prod[95:32];
      q32fx_pkg::OP_DIV_Q32: begin
        if (it.b == 64'd0) begin
          r.dbz = 1'b1;
        end else begin
          num = {64'd0, ma} << 32;
          quo = num / {64'd0, mb};
          r.res = (it.a[63] != it.b[63]) ? -quo[63:0] : quo[63:0];
        end
      end
      q32fx_pkg::OP_QUANTIZE: begin
        if (it.b == 64'd0) begin
          r.res = it.a;
        end else begin
          rm = ma % mb;
          if (it.a[63]) rm = -rm;
          r.res = it.a - rm;
        end
      end
      q32fx_pkg::OP_CLAMP_UNIT: begin
        if (it.a[63]) r.res = '0;
        else if (it.a > q32fx_pkg::ONE_Q32) r.res = q32fx_pkg::ONE_Q32;
        else r.res = it.a;
      end
      q32fx_pkg::OP_CLAMP_BAND: begin
        if ($signed(it.a) < $signed(band_lo_m)) r.res = band_lo_m;
        else if ($signed(band_hi_m) < $signed(it.a)) r.res = band_hi_m;
        else r.res = it.a;
      end
      q32fx_pkg::OP_PHASE_DELTA: r.res = it.b - it.a;
      q32fx_pkg::OP_MUL_Q63:     r.res = prod[126:63];
      q32fx_pkg::OP_MUL_LOW:     r.res = prod[63:0];
      q32fx_pkg::OP_FROM_INT:    r.res = it.a << 32;
      default:                   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'sd0 + $signed({{32{v[31]}}, v[31:0]}) >>> $urandom_range(0, 31);
      1: v = {{40{v[63]}}, v[23:0]};
      2: v = $urandom_range(0, 3) << 32;
      3: v = -($urandom_range(0, 3) << 32);
      4: v = {v[63], {63{~v[63]}}};
      5: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // Driver: hold payload until taken, then pull the next item after a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        it = '{operation_i, operand_a_i, operand_b_i};
        expected_results.push_back(predict_alu(it));
        items_sent++;
      end
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        operation_i <= it.op;
        operand_a_i <= it.a;
        operand_b_i <= it.b;
        in_valid_i <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare against the oldest expectation, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h dbz %b", result_o, divide_by_zero_o);
        end else begin
          want = expected_results.pop_front();
          if (want.res !== result_o || want.dbz !== divide_by_zero_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b got %h/%b", want.res, want.dbz,
                       result_o, divide_by_zero_o);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // Watchdog on lack of progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        !rst_ni || cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_band(logic [q32fx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == q32fx_pkg::REG_BAND_LOW) band_lo_m = val;
    else band_hi_m = val;
  endtask

  task automatic drain_pipe();
    wait (pending_items.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_op(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    pending_items.push_back('{op, a, b});
  endtask

  task automatic push_random(int unsigned n);
    logic [3:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      if ($urandom_range(0, 15) == 0) push_op(op, rand_operand(), 64'd0);
      else push_op(op, rand_operand(), rand_operand());
    end
  endtask

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, every operation, zero divisor and zero step.
    push_op(q32fx_pkg::OP_ABS, MIN64, 64'd0);
    push_op(q32fx_pkg::OP_ABS, -64'd5, 64'd0);
    push_op(q32fx_pkg::OP_MUL_Q32, MIN64, MIN64);
    push_op(q32fx_pkg::OP_MUL_Q32, MAX64, -64'd1);
    push_op(q32fx_pkg::OP_DIV_Q32, MAX64, 64'd0);
    push_op(q32fx_pkg::OP_DIV_Q32, MIN64, -64'd1);
    push_op(q32fx_pkg::OP_DIV_Q32, -64'd7, 64'd2);
    push_op(q32fx_pkg::OP_QUANTIZE, -64'd7, 64'd2);
    push_op(q32fx_pkg::OP_QUANTIZE, MIN64, 64'd0);
    push_op(q32fx_pkg::OP_QUANTIZE, MIN64, -64'd1);
    push_op(q32fx_pkg::OP_CLAMP_UNIT, MIN64, 64'd0);
    push_op(q32fx_pkg::OP_CLAMP_UNIT, q32fx_pkg::ONE_Q32 + 1, 64'd0);
    push_op(q32fx_pkg::OP_CLAMP_UNIT, q32fx_pkg::ONE_Q32, 64'd0);
    push_op(q32fx_pkg::OP_CLAMP_BAND, -64'd1, 64'd0);
    push_op(q32fx_pkg::OP_CLAMP_BAND, MAX64, 64'd0);
    push_op(q32fx_pkg::OP_PHASE_DELTA, MAX64, MIN64);
    push_op(q32fx_pkg::OP_MUL_Q63, MIN64, MIN64);
    push_op(q32fx_pkg::OP_MUL_LOW, MAX64, MAX64);
    push_op(q32fx_pkg::OP_FROM_INT, -64'd1, 64'd0);
    push_op(4'd15, MAX64, MAX64);
    push_op(4'd10, -64'd1, -64'd1);
    push_random(300);
    drain_pipe();
    // Crossed band.
    write_band(q32fx_pkg::REG_BAND_LOW, q32fx_pkg::ONE_Q32);
    write_band(q32fx_pkg::REG_BAND_HIGH, -q32fx_pkg::ONE_Q32);
    for (int i = 0; i < 60; i++)
      push_op(q32fx_pkg::OP_CLAMP_BAND, rand_operand(), rand_operand());
    push_random(150);
    drain_pipe();
    // Full range band, then inverted full range band, then random band.
    write_band(q32fx_pkg::REG_BAND_LOW, MIN64);
    write_band(q32fx_pkg::REG_BAND_HIGH, MAX64);
    push_random(150);
    drain_pipe();
    write_band(q32fx_pkg::REG_BAND_LOW, MAX64);
    write_band(q32fx_pkg::REG_BAND_HIGH, MIN64);
    push_random(80);
    drain_pipe();
    write_band(q32fx_pkg::REG_BAND_LOW, -(64'($urandom) << 8));
    write_band(q32fx_pkg::REG_BAND_HIGH, 64'($urandom) << 8);
    for (int i = 0; i < 60; i++)
      push_op(q32fx_pkg::OP_CLAMP_BAND, rand_operand(), 64'd0);
    gaps_on = 1'b0;
    push_random(120);
    wait (pending_items.size() == 0);
    gaps_on = 1'b1;
    push_random(150);
    drain_pipe();
    $display("ran %0d items across 5 band settings, %0d results checked",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
